[hw/rtl/hsd_pkg.sv]
`default_nettype none

package hsd_pkg;

    localparam int BITS_PER_BYTE      = 8;
    localparam int DEF_MAX_DATA_BYTES = 4;
    localparam int CFG_W              = 3;
    localparam int CFG_RESET_BYTES    = 4;

    localparam logic [1:0] ST_CLEAN   = 2'd0;
    localparam logic [1:0] ST_SINGLE  = 2'd1;
    localparam logic [1:0] ST_OVERALL = 2'd2;
    localparam logic [1:0] ST_DOUBLE  = 2'd3;

    // code positions n = k + r for a block of 'bytes' data bytes
    function automatic int f_positions(input int bytes);
        int k;
        int r;
        k = bytes * BITS_PER_BYTE;
        r = 0;
        for (int i = 0; i < 8; i++) begin
            if ((1 << i) <= k) begin
                r = i + 1;
            end
        end
        return k + r;
    endfunction

    // 1-based code position of data bit d (d-th position that is not a power of two)
    function automatic int f_data_pos(input int d);
        int cnt;
        int pos;
        cnt = 0;
        pos = 0;
        for (int p = 1; p < 128; p++) begin
            if ((p & (p - 1)) != 0) begin
                if (cnt == d && pos == 0) begin
                    pos = p;
                end
                cnt++;
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/hamming_secded_decoder.sv]
// Extended Hamming SECDED decoder, one codeword per request.
// Pipeline stages, in order: capture/mask, syndrome, correct; o_valid is the
// registered valid of the correct stage.
// Throughput: one codeword per cycle; an output stall holds full stages, bubbles close up.
// Reset (synchronous, i_rst_n low): all stage valids clear, block length returns to
// four data bytes (clamped to MAX_DATA_BYTES).
`default_nettype none

module hamming_secded_decoder #(
    parameter int MAX_DATA_BYTES = hsd_pkg::DEF_MAX_DATA_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // codeword channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [hsd_pkg::f_positions(MAX_DATA_BYTES):0] i_codeword,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [hsd_pkg::BITS_PER_BYTE*MAX_DATA_BYTES-1:0] o_data_out,
    output logic [1:0]                    o_status,
    output logic [$clog2(hsd_pkg::f_positions(MAX_DATA_BYTES)+1)-1:0] o_error_position,
    // configuration
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hsd_pkg::CFG_W-1:0]     i_cfg_data_bytes_used
);

    import hsd_pkg::*;

    localparam int N_MAX  = f_positions(MAX_DATA_BYTES);
    localparam int DATA_W = BITS_PER_BYTE * MAX_DATA_BYTES;
    localparam int POS_W  = $clog2(N_MAX + 1);
    localparam int RST_BYTES =
        (CFG_RESET_BYTES > MAX_DATA_BYTES) ? MAX_DATA_BYTES : CFG_RESET_BYTES;
    localparam logic [POS_W-1:0] RST_N = POS_W'(f_positions(RST_BYTES));

    // ---------------- configuration: keep the position count n ----------------
    logic [POS_W-1:0]  r_n;
    logic [CFG_W-1:0]  n_bytes;
    logic [POS_W-1:0]  n_n;

    always_comb begin
        if (i_cfg_data_bytes_used == '0) begin
            n_bytes = CFG_W'(1);
        end else if (i_cfg_data_bytes_used > CFG_W'(MAX_DATA_BYTES)) begin
            n_bytes = CFG_W'(MAX_DATA_BYTES);
        end else begin
            n_bytes = i_cfg_data_bytes_used;
        end
        n_n = POS_W'(f_positions(int'(n_bytes)));
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= RST_N;
        end else if (i_cfg_valid) begin
            r_n <= n_n;
        end
    end

    // ---------------- pipeline control ----------------
    logic r_s1_v, r_s2_v, r_s3_v;
    logic rdy1, rdy2, rdy3;

    assign rdy3    = !r_s3_v || i_ready;
    assign rdy2    = !r_s2_v || rdy3;
    assign rdy1    = !r_s1_v || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_s3_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (rdy1) begin
                r_s1_v <= i_valid;
            end
            if (rdy2) begin
                r_s2_v <= r_s1_v;
            end
            if (rdy3) begin
                r_s3_v <= r_s2_v;
            end
        end
    end

    // ---------------- stage 1: drop positions beyond n, pick overall bit ----------------
    logic [N_MAX-1:0] r_s1_word;
    logic             r_s1_ov;
    logic [N_MAX-1:0] n_s1_word;

    always_comb begin
        for (int p = 1; p <= N_MAX; p++) begin
            n_s1_word[p-1] = i_codeword[p-1] && (POS_W'(p) <= r_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && rdy1) begin
            r_s1_word <= n_s1_word;
            r_s1_ov   <= i_codeword[r_n];
        end
    end

    // ---------------- stage 2: syndrome and overall parity ----------------
    logic [N_MAX-1:0] r_s2_word;
    logic [POS_W-1:0] r_s2_syn;
    logic             r_s2_par;
    logic [POS_W-1:0] n_s2_syn;

    always_comb begin
        n_s2_syn = '0;
        for (int p = 1; p <= N_MAX; p++) begin
            if (r_s1_word[p-1]) begin
                n_s2_syn = n_s2_syn ^ POS_W'(p);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_v && rdy2) begin
            r_s2_word <= r_s1_word;
            r_s2_syn  <= n_s2_syn;
            r_s2_par  <= (^r_s1_word) ^ r_s1_ov;
        end
    end

    // ---------------- stage 3: classify, correct, gather data bits ----------------
    logic [1:0]        n_s3_status;
    logic [POS_W-1:0]  n_s3_epos;
    logic [N_MAX-1:0]  n_s3_flip;
    logic [N_MAX-1:0]  n_s3_word;
    logic [DATA_W-1:0] n_s3_data;

    always_comb begin
        n_s3_epos = '0;
        n_s3_flip = '0;
        if (r_s2_syn == '0 && !r_s2_par) begin
            n_s3_status = ST_CLEAN;
        end else if (r_s2_syn == '0) begin
            n_s3_status = ST_OVERALL;
        end else if (r_s2_par && r_s2_syn <= r_n) begin
            // syndrome points inside the (possibly shortened) code
            n_s3_status = ST_SINGLE;
            n_s3_epos   = r_s2_syn;
            n_s3_flip   = {{(N_MAX-1){1'b0}}, 1'b1} << (r_s2_syn - POS_W'(1));
        end else begin
            n_s3_status = ST_DOUBLE;
        end
        n_s3_word = r_s2_word ^ n_s3_flip;
    end

    for (genvar d = 0; d < DATA_W; d++) begin : g_data
        localparam int P = f_data_pos(d);
        assign n_s3_data[d] = n_s3_word[P-1];
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_v && rdy3) begin
            o_data_out       <= n_s3_data;
            o_status         <= n_s3_status;
            o_error_position <= n_s3_epos;
        end
    end

`ifndef SYNTH
    a_single_has_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_SINGLE) |-> (o_error_position != '0))
        else $error("single correction without position");

    a_pos_only_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_SINGLE) |-> (o_error_position == '0))
        else $error("position reported without correction");

    a_backpressure_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_s1_v && r_s2_v && r_s3_v && !i_ready))
        else $error("input stalled with a bubble in the pipeline");

    a_n_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cfg_valid) |-> (r_n <= POS_W'(N_MAX) && r_n >= POS_W'(f_positions(1))))
        else $error("block length out of range");
`endif

endmodule

`default_nettype wire

[sim/hamming_secded_checker.sv]
`timescale 1ns / 1ps

module hamming_secded_checker #(
    parameter int MAX_BYTES = hsd_pkg::DEF_MAX_DATA_BYTES
) (
    input  logic                                                    i_clk,
    input  logic                                                    i_rst_n,
    input  logic                                                    i_cw_valid,
    input  logic                                                    i_cw_ready,
    input  logic [hsd_pkg::f_positions(MAX_BYTES):0]                i_codeword,
    input  logic                                                    i_res_valid,
    input  logic                                                    i_res_ready,
    input  logic [hsd_pkg::BITS_PER_BYTE*MAX_BYTES-1:0]             i_data_out,
    input  logic [1:0]                                              i_status,
    input  logic [$clog2(hsd_pkg::f_positions(MAX_BYTES)+1)-1:0]    i_error_position,
    input  logic                                                    i_cfg_valid,
    input  logic                                                    i_cfg_ready,
    input  logic [hsd_pkg::CFG_W-1:0]                               i_cfg_data,
    output int                                                      o_fail_count,
    output int                                                      o_pending
);

    localparam int CW_W   = hsd_pkg::f_positions(MAX_BYTES) + 1;
    localparam int DATA_W = hsd_pkg::BITS_PER_BYTE * MAX_BYTES;
    localparam int EPOS_W = $clog2(hsd_pkg::f_positions(MAX_BYTES) + 1);

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [1:0]        status;
        logic [EPOS_W-1:0] pos;
    } t_decode;

    t_decode                   decoded_q[$];
    logic [hsd_pkg::CFG_W-1:0] bytes_reg;

    function automatic t_decode secded_decode(input logic [CW_W-1:0] cw,
                                              input logic [hsd_pkg::CFG_W-1:0] bytes_cfg);
        int      b;
        int      k;
        int      r;
        int      n;
        int      syn;
        int      dpos;
        logic    odd;
        logic [CW_W-1:0] w;
        t_decode d;
        b = bytes_cfg;
        if (b < 1) b = 1;
        if (b > MAX_BYTES) b = MAX_BYTES;
        k = b * hsd_pkg::BITS_PER_BYTE;
        r = 0;
        while (r < 8 && (1 << r) <= k) r++;
        n = k + r;
        w = cw;
        syn = 0;
        odd = 1'b0;
        for (int p = 1; p <= n; p++) begin
            if (w[p-1]) begin
                syn ^= p;
                odd = ~odd;
            end
        end
        odd ^= w[n];
        d = '0;
        if (syn == 0 && !odd) begin
            d.status = hsd_pkg::ST_CLEAN;
        end else if (syn == 0) begin
            d.status = hsd_pkg::ST_OVERALL;
        end else if (odd && syn <= n) begin
            d.status = hsd_pkg::ST_SINGLE;
            d.pos    = EPOS_W'(syn);
            w[syn-1] = ~w[syn-1];
        end else begin
            // even parity with nonzero syndrome, or syndrome outside the shortened code
            d.status = hsd_pkg::ST_DOUBLE;
        end
        dpos = 0;
        for (int p = 1; p <= n; p++) begin
            if ((p & (p - 1)) != 0) begin
                if (dpos < DATA_W) d.data[dpos] = w[p-1];
                dpos++;
            end
        end
        return d;
    endfunction

    always @(posedge i_clk) begin
        t_decode exp_res;
        int      errs;
        errs = 0;
        if (!i_rst_n) begin
            bytes_reg = hsd_pkg::CFG_W'(hsd_pkg::CFG_RESET_BYTES);
            decoded_q.delete();
            o_fail_count <= 0;
        end else begin
            // pop before enqueue: a result never belongs to a request taken on the same edge
            if (i_res_valid && i_res_ready) begin
                if (decoded_q.size() == 0) begin
                    $error("result with no request outstanding: data_out %h", i_data_out);
                    errs++;
                end else begin
                    exp_res = decoded_q.pop_front();
                    if (i_data_out !== exp_res.data) begin
                        $error("data_out: expected %h, actual %h", exp_res.data, i_data_out);
                        errs++;
                    end
                    if (i_status !== exp_res.status) begin
                        $error("status: expected %0d, actual %0d", exp_res.status, i_status);
                        errs++;
                    end
                    if (i_error_position !== exp_res.pos) begin
                        $error("error_position: expected %0d, actual %0d",
                               exp_res.pos, i_error_position);
                        errs++;
                    end
                end
            end
            if (i_cw_valid && i_cw_ready) begin
                decoded_q = {decoded_q, secded_decode(i_codeword, bytes_reg)};
            end
            if (i_cfg_valid && i_cfg_ready) begin
                bytes_reg = i_cfg_data;
            end
            o_fail_count <= o_fail_count + errs;
        end
        o_pending <= decoded_q.size();
    end

endmodule

[sim/tb_hamming_secded_decoder.sv]
`timescale 1ns / 1ps

module tb_hamming_secded_decoder;

    localparam int MAX_BYTES        = hsd_pkg::DEF_MAX_DATA_BYTES;
    localparam int CW_W             = hsd_pkg::f_positions(MAX_BYTES) + 1;
    localparam int DATA_W           = hsd_pkg::BITS_PER_BYTE * MAX_BYTES;
    localparam int EPOS_W           = $clog2(hsd_pkg::f_positions(MAX_BYTES) + 1);
    localparam int NUM_PHASES       = 8;
    localparam int RANDOM_PER_PHASE = 125;
    localparam int HOLD_CYCLES      = 200;
    localparam int STALL_LIMIT      = 3000;
    localparam int DRAIN_CYCLES     = 8;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic [CW_W-1:0]           i_codeword = '0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic [DATA_W-1:0]         o_data_out;
    logic [1:0]                o_status;
    logic [EPOS_W-1:0]         o_error_position;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [hsd_pkg::CFG_W-1:0] i_cfg_data_bytes_used = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req = 1'b0;
    int fail_count;
    int pending_cnt;
    int stall_cycles = 0;

    hamming_secded_decoder #(
        .MAX_DATA_BYTES(MAX_BYTES)
    ) dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_ready               (o_ready),
        .i_codeword            (i_codeword),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_data_out            (o_data_out),
        .o_status              (o_status),
        .o_error_position      (o_error_position),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_data_bytes_used (i_cfg_data_bytes_used)
    );

    hamming_secded_checker #(
        .MAX_BYTES(MAX_BYTES)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cw_valid       (i_valid),
        .i_cw_ready       (o_ready),
        .i_codeword       (i_codeword),
        .i_res_valid      (o_valid),
        .i_res_ready      (i_ready),
        .i_data_out       (o_data_out),
        .i_status         (o_status),
        .i_error_position (o_error_position),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data_bytes_used),
        .o_fail_count     (fail_count),
        .o_pending        (pending_cnt)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic int clamp_bytes(input logic [hsd_pkg::CFG_W-1:0] v);
        int b;
        b = v;
        if (b < 1) b = 1;
        if (b > MAX_BYTES) b = MAX_BYTES;
        return b;
    endfunction

    function automatic logic [CW_W-1:0] encode_word(input logic [DATA_W-1:0] d, input int b);
        int              n;
        int              j;
        int              pos;
        logic            par;
        logic [CW_W-1:0] cw;
        cw = '0;
        n = hsd_pkg::f_positions(b);
        for (j = 0; j < b * hsd_pkg::BITS_PER_BYTE; j++) begin
            cw[hsd_pkg::f_data_pos(j) - 1] = d[j];
        end
        for (j = 0; (1 << j) <= n; j++) begin
            par = 1'b0;
            for (pos = 1; pos <= n; pos++) begin
                if ((pos & (1 << j)) != 0) par ^= cw[pos-1];
            end
            cw[(1 << j) - 1] = par;
        end
        par = 1'b0;
        for (pos = 0; pos < n; pos++) par ^= cw[pos];
        cw[n] = par;
        return cw;
    endfunction

    // mostly valid codewords with 0..3 flipped bits, some raw noise
    function automatic logic [CW_W-1:0] random_codeword(input logic [hsd_pkg::CFG_W-1:0] v);
        int              b;
        int              n;
        int              kind;
        int              flips;
        int              idx;
        logic [CW_W-1:0] cw;
        logic [CW_W-1:0] used;
        b = clamp_bytes(v);
        n = hsd_pkg::f_positions(b);
        kind = $urandom_range(99);
        if (kind < 10) begin
            cw = CW_W'({$urandom(), $urandom()});
        end else begin
            cw = encode_word(DATA_W'($urandom()), b);
            flips = (kind < 35) ? 0 : (kind < 65) ? 1 : (kind < 85) ? 2 : 3;
            used = '0;
            while (flips > 0) begin
                idx = $urandom_range(n, 0);
                if (!used[idx]) begin
                    used[idx] = 1'b1;
                    cw[idx] = ~cw[idx];
                    flips--;
                end
            end
            if ($urandom_range(99) < 30) begin
                for (idx = n + 1; idx < CW_W; idx++) cw[idx] = 1'($urandom_range(1));
            end
        end
        return cw;
    endfunction

    task automatic send_word(input logic [CW_W-1:0] cw);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_codeword <= cw;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic write_bytes_used(input logic [hsd_pkg::CFG_W-1:0] v);
        i_cfg_valid           <= 1'b1;
        i_cfg_data_bytes_used <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain_requests();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_cnt != 0) @(negedge i_clk);
    endtask

    // result side: random backpressure, or one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_hamming_secded_decoder failed");
            $finish;
        end
    end

    initial begin
        logic [hsd_pkg::CFG_W-1:0] cfg_plan [NUM_PHASES];
        logic [CW_W-1:0]           base;
        cfg_plan = '{3'd4, 3'd1, 3'd7, 3'd2, 3'd0, 3'd3, 3'd5, 3'd4};
        cfg_plan[NUM_PHASES-1] = hsd_pkg::CFG_W'($urandom_range(7));

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed words at the reset length (32 data bits, 38 positions)
        send_idle_pct = 15;
        recv_idle_pct = 81;
        base = encode_word(32'h1234_5678, MAX_BYTES);
        send_word('0);
        send_word('1);
        send_word(encode_word(32'hFFFF_FFFF, MAX_BYTES));
        send_word(encode_word(32'h0000_0001, MAX_BYTES));
        send_word(encode_word(32'h8000_0000, MAX_BYTES));
        send_word(encode_word(32'hA5A5_5A5A, MAX_BYTES));
        send_word(base);
        send_word(base ^ (CW_W'(1) << 0));
        send_word(base ^ (CW_W'(1) << 2));
        send_word(base ^ (CW_W'(1) << 31));
        send_word(base ^ (CW_W'(1) << (CW_W - 2)));
        // overall parity bit alone
        send_word(base ^ (CW_W'(1) << (CW_W - 1)));
        send_word(base ^ (CW_W'(1) << 0) ^ (CW_W'(1) << 1));
        send_word(base ^ (CW_W'(1) << 36) ^ (CW_W'(1) << 37));
        // three flips: syndrome 39 lies beyond the code
        send_word(base ^ (CW_W'(1) << 0) ^ (CW_W'(1) << 5) ^ (CW_W'(1) << 31));
        // three flips that alias to a single error
        send_word(base ^ (CW_W'(1) << 0) ^ (CW_W'(1) << 1) ^ (CW_W'(1) << 3));
        send_word(CW_W'({$urandom(), $urandom()}));

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_requests();
            send_idle_pct = (p < 3) ? 15 : (p < 6) ? 81 : 0;
            recv_idle_pct = (p < 3) ? 81 : (p < 6) ? 15 : 0;
            write_bytes_used(cfg_plan[p]);
            if (p == 6) hold_req = 1'b1;
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                send_word(random_codeword(cfg_plan[p]));
            end
        end

        drain_requests();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending_cnt == 0) begin
            $display("tb_hamming_secded_decoder passed");
        end else begin
            $display("tb_hamming_secded_decoder failed");
        end
        $finish;
    end

endmodule
